// ===== rtl/go_back_n_sender_macros.svh =====
// ----------------------------------------------------------------------------
// go_back_n_sender assertion macros
// Shared property forms for the sender's internal checks.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH

// same-cycle implication
`define GBN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gbn check failed");

// next-cycle implication
`define GBN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gbn check failed");

`endif

// ===== rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, codes and constants shared by the Go-Back-N sender modules.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int CHUNK_BYTES_DEF = 1024;
    localparam int MAX_WINDOW_DEF  = 64;

    localparam int SEQ_W       = 32;
    localparam int BYTES_W     = 32;
    localparam int LEN_W       = 11;
    localparam int WIN_W       = 7;
    localparam int TRY_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TUSER_W   = 3;
    localparam int S_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;
    localparam int M_TDATA_W   = 80;
    localparam int M_PAD_W     = M_TDATA_W - SEQ_W - BYTES_W - LEN_W;

    localparam logic [WIN_W-1:0] WINDOW_RST    = 7'd8;
    localparam logic [TRY_W-1:0] FIN_LIMIT_RST = 4'd10;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_RX      = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIN_LIMIT   = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_FIN  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEND = 2'd1,
        PH_FIN  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_BASE,
        S_EVAL,
        S_SINGLE
    } seq_state_t;

    typedef struct packed {
        logic                below;
        logic [BYTES_W-1:0]  diff;
        logic [BYTES_W-1:0]  offset;
    } arith_res_t;

    typedef struct packed {
        kind_t               kind;
        logic [SEQ_W-1:0]    seq;
        logic [BYTES_W-1:0]  offset;
        logic [LEN_W-1:0]    len;
        logic                last;
    } desc_t;

endpackage

// ===== rtl/gbn_arith.sv =====
// ----------------------------------------------------------------------------
// gbn_arith
// Shared offset unit: seq * chunk size, then compare and subtract against
// the transfer length. Two register stages.
// ----------------------------------------------------------------------------
module gbn_arith #(
    parameter int CHUNK_BYTES = gbn_pkg::CHUNK_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic [gbn_pkg::SEQ_W-1:0]    operand,
    input  logic [gbn_pkg::BYTES_W-1:0]  total_bytes,
    output gbn_pkg::arith_res_t          res
);
    import gbn_pkg::*;

    localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
    localparam int PROD_W  = SEQ_W + CHUNK_W;
    localparam logic [CHUNK_W-1:0] CHUNK_C = CHUNK_W'(CHUNK_BYTES);

    logic [PROD_W-1:0] prod_reg;
    arith_res_t        res_reg;
    arith_res_t        res_next;

    always_comb begin
        res_next.below  = prod_reg < {{CHUNK_W{1'b0}}, total_bytes};
        res_next.diff   = total_bytes - prod_reg[BYTES_W-1:0];
        res_next.offset = prod_reg[BYTES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= {{CHUNK_W{1'b0}}, operand} * {{SEQ_W{1'b0}}, CHUNK_C};
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/gbn_seq.sv =====
// ----------------------------------------------------------------------------
// gbn_seq
// Sender sequencer: window state, event decode, descriptor walk over the
// shared offset unit, one-beat hold for the last flag and output register.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_macros.svh"

module gbn_seq #(
    parameter int CHUNK_BYTES = gbn_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_WINDOW  = gbn_pkg::MAX_WINDOW_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic                         rx_is_ack,
    input  logic [gbn_pkg::SEQ_W-1:0]    ack_number,
    input  logic [gbn_pkg::BYTES_W-1:0]  total_bytes,
    input  logic [gbn_pkg::WIN_W-1:0]    window_size,
    input  logic [gbn_pkg::TRY_W-1:0]    fin_retry_limit,
    output logic [gbn_pkg::SEQ_W-1:0]    operand,
    input  gbn_pkg::arith_res_t          res,
    output logic                         out_valid,
    input  logic                         out_ready,
    output gbn_pkg::desc_t               out_desc
);
    import gbn_pkg::*;

    localparam logic [WIN_W-1:0]   MAX_WIN_C = WIN_W'(MAX_WINDOW);
    localparam logic [BYTES_W-1:0] CHUNK_C   = BYTES_W'(CHUNK_BYTES);

    seq_state_t          state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [SEQ_W-1:0]    base_reg, base_next;
    logic [SEQ_W-1:0]    nseq_reg, nseq_next;
    logic [TRY_W-1:0]    tries_reg, tries_next;
    logic [SEQ_W-1:0]    cur_reg, cur_next;
    logic                chk_reg, chk_next;
    logic                win_ok_reg, win_ok_next;
    logic                pend_valid_reg, pend_valid_next;
    desc_t               pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    desc_t               out_reg, out_next;
    kind_t               single_kind_reg, single_kind_next;
    logic [SEQ_W-1:0]    single_seq_reg, single_seq_next;

    logic [WIN_W-1:0]    eff_win;
    logic [TRY_W-1:0]    fin_lim;
    logic                fin_more;
    logic                ack_hit;
    logic                out_free;
    logic                emit_ok;
    logic [BYTES_W-1:0]  clamp;
    logic [LEN_W-1:0]    len;

    always_comb begin
        if (window_size == '0) begin
            eff_win = WIN_W'(1);
        end else if (window_size > MAX_WIN_C) begin
            eff_win = MAX_WIN_C;
        end else begin
            eff_win = window_size;
        end
    end

    assign fin_lim  = (fin_retry_limit == '0) ? TRY_W'(1) : fin_retry_limit;
    assign fin_more = tries_reg < fin_lim;
    assign ack_hit  = rx_is_ack && (ack_number >= base_reg) && (ack_number < nseq_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign emit_ok  = (cur_reg != nseq_reg) || (win_ok_reg && res.below);
    assign clamp    = (res.diff > CHUNK_C) ? CHUNK_C : res.diff;
    assign len      = res.below ? clamp[LEN_W-1:0] : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (mode)
                        MODE_START: begin
                            state_next = (total_bytes == '0) ? S_SINGLE : S_MUL;
                        end
                        MODE_RX: begin
                            if (phase_reg == PH_SEND && ack_hit) begin
                                state_next = S_MUL;
                            end else if (phase_reg == PH_FIN) begin
                                state_next = S_SINGLE;
                            end
                        end
                        MODE_TIMEOUT: begin
                            if (phase_reg == PH_SEND) begin
                                state_next = S_MUL;
                            end else if (phase_reg == PH_FIN) begin
                                state_next = S_SINGLE;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:  state_next = S_CMP;
            S_CMP:  state_next = chk_reg ? S_BASE : S_EVAL;
            S_BASE: state_next = res.below ? S_MUL : S_SINGLE;
            S_EVAL: begin
                if (emit_ok) begin
                    if (!pend_valid_reg || out_free) begin
                        state_next = S_MUL;
                    end
                end else if (!pend_valid_reg || out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        phase_next       = phase_reg;
        base_next        = base_reg;
        nseq_next        = nseq_reg;
        tries_next       = tries_reg;
        cur_next         = cur_reg;
        chk_next         = chk_reg;
        win_ok_next      = win_ok_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        single_kind_next = single_kind_reg;
        single_seq_next  = single_seq_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (mode)
                        MODE_START: begin
                            base_next = '0;
                            nseq_next = '0;
                            cur_next  = '0;
                            chk_next  = 1'b0;
                            if (total_bytes == '0) begin
                                phase_next       = PH_FIN;
                                tries_next       = TRY_W'(1);
                                single_kind_next = KIND_FIN;
                                single_seq_next  = '0;
                            end else begin
                                phase_next = PH_SEND;
                                tries_next = '0;
                            end
                        end
                        MODE_RX: begin
                            if (phase_reg == PH_SEND) begin
                                if (ack_hit) begin
                                    base_next = ack_number + SEQ_W'(1);
                                    cur_next  = ack_number + SEQ_W'(1);
                                    chk_next  = 1'b1;
                                end
                            end else if (phase_reg == PH_FIN) begin
                                if (rx_is_ack || !fin_more) begin
                                    phase_next       = PH_DONE;
                                    single_kind_next = KIND_DONE;
                                    single_seq_next  = '0;
                                end else begin
                                    tries_next       = tries_reg + TRY_W'(1);
                                    single_kind_next = KIND_FIN;
                                    single_seq_next  = nseq_reg;
                                end
                            end
                        end
                        MODE_TIMEOUT: begin
                            if (phase_reg == PH_SEND) begin
                                cur_next = base_reg;
                                chk_next = 1'b0;
                            end else if (phase_reg == PH_FIN) begin
                                if (fin_more) begin
                                    tries_next       = tries_reg + TRY_W'(1);
                                    single_kind_next = KIND_FIN;
                                    single_seq_next  = nseq_reg;
                                end else begin
                                    phase_next       = PH_DONE;
                                    single_kind_next = KIND_DONE;
                                    single_seq_next  = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL: begin
            end
            S_CMP: begin
                win_ok_next = {1'b0, cur_reg} < ({1'b0, base_reg} + (SEQ_W+1)'(eff_win));
            end
            S_BASE: begin
                if (res.below) begin
                    cur_next = nseq_reg;
                    chk_next = 1'b0;
                end else begin
                    phase_next       = PH_FIN;
                    tries_next       = tries_reg + TRY_W'(1);
                    single_kind_next = KIND_FIN;
                    single_seq_next  = nseq_reg;
                end
            end
            S_EVAL: begin
                if (emit_ok) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_next.kind   = KIND_DATA;
                        pend_next.seq    = cur_reg;
                        pend_next.offset = res.offset;
                        pend_next.len    = len;
                        pend_next.last   = 1'b0;
                        if (cur_reg == nseq_reg) begin
                            nseq_next = nseq_reg + SEQ_W'(1);
                        end
                        cur_next = cur_reg + SEQ_W'(1);
                    end
                end else if (pend_valid_reg && out_free) begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next.kind  = single_kind_reg;
                    out_next.seq   = single_seq_reg;
                    out_next.offset = '0;
                    out_next.len   = '0;
                    out_next.last  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            base_reg       <= '0;
            nseq_reg       <= '0;
            tries_reg      <= '0;
            chk_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            base_reg       <= base_next;
            nseq_reg       <= nseq_next;
            tries_reg      <= tries_next;
            chk_reg        <= chk_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg         <= cur_next;
        win_ok_reg      <= win_ok_next;
        pend_reg        <= pend_next;
        out_reg         <= out_next;
        single_kind_reg <= single_kind_next;
        single_seq_reg  <= single_seq_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign operand   = cur_reg;
    assign out_valid = out_valid_reg;
    assign out_desc  = out_reg;

    `GBN_ASSERT_IMP(a_no_hold_when_idle, aclk, aresetn, (state_reg == S_IDLE) || (state_reg == S_SINGLE) || (state_reg == S_BASE), !pend_valid_reg)
    `GBN_ASSERT_IMP(a_window_bound, aclk, aresetn, phase_reg == PH_SEND, (base_reg <= nseq_reg) && ((nseq_reg - base_reg) <= SEQ_W'(MAX_WINDOW)))
    `GBN_ASSERT_IMP(a_more_follows, aclk, aresetn, out_valid_reg && !out_reg.last, pend_valid_reg)
    `GBN_ASSERT_NXT(a_single_last, aclk, aresetn, (state_reg == S_SINGLE) && out_free, out_valid_reg && out_reg.last)

endmodule

// ===== rtl/go_back_n_sender.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N ARQ sender control: turns start, receive and timeout events
// into data, FIN and finished descriptors.
// ----------------------------------------------------------------------------
// Input beats carry one event: s_tuser = {rx_is_ack, mode}, s_tdata = ack_number.
// Each event yields zero or more descriptor beats on the m_ side; m_tlast marks
// the final beat of an event. Registers are set through cfg_wr_en/cfg_index/
// cfg_wdata; the user must write them only while no event is in flight, as the
// block does not enforce this itself. The block takes one event at a time;
// s_tready is high only between events. An event with a single result (FIN,
// finished) passes from the idle state through S_SINGLE to the output register.
// A data walk passes each descriptor through the shared offset unit in order
// (multiply, compare/subtract, decide); an ACK first adds a base check.
// Output is registered; while m_tready is low the walk stalls with one
// descriptor held back, and resumes when the beat is taken.
// Reset (aresetn low, synchronous) returns to the idle phase with base and
// next sequence at zero and registers at total 0, window 8, FIN limit 10.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
    parameter int CHUNK_BYTES = gbn_pkg::CHUNK_BYTES_DEF,
    parameter int MAX_WINDOW  = gbn_pkg::MAX_WINDOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbn_pkg::BYTES_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gbn_pkg::S_TDATA_W-1:0]   s_tdata,   // ack_number
    input  logic [gbn_pkg::S_TUSER_W-1:0]   s_tuser,   // mode[1:0], rx_is_ack
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gbn_pkg::M_TDATA_W-1:0]   m_tdata,   // seq_number, byte_offset, chunk_length, pad
    output logic [gbn_pkg::M_TUSER_W-1:0]   m_tuser,   // kind
    output logic                            m_tlast
);
    import gbn_pkg::*;

    logic [BYTES_W-1:0] total_bytes_reg;
    logic [WIN_W-1:0]   window_size_reg;
    logic [TRY_W-1:0]   fin_limit_reg;
    logic [SEQ_W-1:0]   operand;
    arith_res_t         res;
    desc_t              desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_bytes_reg <= '0;
            window_size_reg <= WINDOW_RST;
            fin_limit_reg   <= FIN_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TOTAL_BYTES: total_bytes_reg <= cfg_wdata;
                CFG_WINDOW_SIZE: window_size_reg <= cfg_wdata[WIN_W-1:0];
                CFG_FIN_LIMIT:   fin_limit_reg   <= cfg_wdata[TRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gbn_arith #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_arith (
        .aclk        (aclk),
        .operand     (operand),
        .total_bytes (total_bytes_reg),
        .res         (res)
    );

    gbn_seq #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .mode            (s_tuser[1:0]),
        .rx_is_ack       (s_tuser[2]),
        .ack_number      (s_tdata),
        .total_bytes     (total_bytes_reg),
        .window_size     (window_size_reg),
        .fin_retry_limit (fin_limit_reg),
        .operand         (operand),
        .res             (res),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_desc        (desc)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, desc.len, desc.offset, desc.seq};
    assign m_tuser = desc.kind;
    assign m_tlast = desc.last;

endmodule

// ===== tb/sv/tb_go_back_n_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_back_n_sender
// Self-checking bench for the Go-Back-N sender. Events go in on the s_ stream
// and a cycle-free model of the window predicts every descriptor beat. Each
// beat on the m_ stream is checked against the oldest prediction. Directed
// tests cover idle, empty, FIN and window corner cases. A stalled-receiver
// test follows, then random transfers with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender;
    import gbn_pkg::*;

    localparam int CHUNK          = CHUNK_BYTES_DEF;
    localparam int MAX_WIN        = MAX_WINDOW_DEF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_EVENTS  = 345;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [BYTES_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    go_back_n_sender dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // window model
    logic [BYTES_W-1:0] cfg_total;
    logic [WIN_W-1:0]   cfg_window;
    logic [TRY_W-1:0]   cfg_fin_limit;
    logic [SEQ_W-1:0]   win_base;
    logic [SEQ_W-1:0]   next_seq;
    phase_t             tx_phase;
    logic [TRY_W-1:0]   fin_tries;

    desc_t event_descs[$];
    desc_t expected_descs[$];
    int    productive_events = 0;
    int    mismatches = 0;
    bit    s_idle_en = 1'b0;
    bit    m_idle_en = 1'b0;
    int    rx_hold_len = 0;
    longint cycle_count = 0;

    function automatic void reset_window_model();
        cfg_total     = '0;
        cfg_window    = WINDOW_RST;
        cfg_fin_limit = FIN_LIMIT_RST;
        win_base      = '0;
        next_seq      = '0;
        tx_phase      = PH_IDLE;
        fin_tries     = '0;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            CFG_TOTAL_BYTES: cfg_total     = value;
            CFG_WINDOW_SIZE: cfg_window    = value[WIN_W-1:0];
            CFG_FIN_LIMIT:   cfg_fin_limit = value[TRY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic longint unsigned packet_count();
        longint unsigned t;
        t = cfg_total;
        return (t + CHUNK - 1) / CHUNK;
    endfunction

    function automatic longint unsigned eff_window();
        if (cfg_window == 0) return 1;
        if (cfg_window > MAX_WIN) return MAX_WIN;
        return cfg_window;
    endfunction

    function automatic void add_desc(kind_t kind, logic [31:0] seq, logic [31:0] off,
                                     logic [LEN_W-1:0] len);
        desc_t d;
        if (event_descs.size() >= MAX_WIN + 1) return;
        d.kind   = kind;
        d.seq    = seq;
        d.offset = off;
        d.len    = len;
        d.last   = 1'b0;
        event_descs.push_back(d);
    endfunction

    function automatic void add_data(logic [31:0] seq);
        longint unsigned off, len, total;
        total = cfg_total;
        off = seq;
        off = off * CHUNK;
        len = 0;
        if (off < total) begin
            len = total - off;
            if (len > CHUNK) len = CHUNK;
        end
        add_desc(KIND_DATA, seq, off[31:0], len[LEN_W-1:0]);
    endfunction

    function automatic void refill_window();
        longint unsigned lim, tp, nx;
        tp  = packet_count();
        lim = win_base;
        lim = lim + eff_window();
        nx  = next_seq;
        while (nx < lim && nx < tp) begin
            add_data(next_seq);
            next_seq = next_seq + 1;
            nx = next_seq;
        end
    endfunction

    function automatic void add_fin();
        tx_phase  = PH_FIN;
        fin_tries = fin_tries + 1'b1;
        add_desc(KIND_FIN, next_seq, '0, '0);
    endfunction

    function automatic void add_done();
        tx_phase = PH_DONE;
        add_desc(KIND_DONE, '0, '0, '0);
    endfunction

    function automatic void retry_fin();
        logic [TRY_W-1:0] lim;
        lim = (cfg_fin_limit == 0) ? 4'd1 : cfg_fin_limit;
        if (fin_tries < lim) add_fin();
        else add_done();
    endfunction

    function automatic void predict_descriptors(logic [1:0] mode, logic is_ack,
                                                logic [31:0] ack);
        logic [SEQ_W-1:0] s;
        longint unsigned b;
        event_descs.delete();
        case (mode)
            MODE_START: begin
                win_base  = '0;
                next_seq  = '0;
                fin_tries = '0;
                if (packet_count() == 0) begin
                    add_fin();
                end else begin
                    tx_phase = PH_SEND;
                    refill_window();
                end
            end
            MODE_RX: begin
                if (tx_phase == PH_SEND) begin
                    if (is_ack && ack >= win_base && ack < next_seq) begin
                        win_base = ack + 1;
                        b = win_base;
                        if (b >= packet_count()) add_fin();
                        else refill_window();
                    end
                end else if (tx_phase == PH_FIN) begin
                    if (is_ack) add_done();
                    else retry_fin();
                end
            end
            MODE_TIMEOUT: begin
                if (tx_phase == PH_SEND) begin
                    for (s = win_base; s != next_seq && event_descs.size() < MAX_WIN; s++)
                        add_data(s);
                    refill_window();
                end else if (tx_phase == PH_FIN) begin
                    retry_fin();
                end
            end
            default: ;
        endcase
        if (event_descs.size() > 0) begin
            event_descs[event_descs.size()-1].last = 1'b1;
            productive_events++;
        end
        foreach (event_descs[i]) expected_descs.push_back(event_descs[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_event(input logic [1:0] mode, input logic is_ack,
                              input logic [31:0] ack);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= {is_ack, mode};
        s_tdata  <= ack;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_descriptors(mode, is_ack, ack);
        gap = s_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_descs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_config(idx, value);
        @(posedge aclk);
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial begin : ready_driver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_len > 0) begin
                hold_left   = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (m_idle_en && $urandom_range(0, 5) == 0) stall_left = pick_stall();
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : desc_check
        desc_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_descs.size() == 0) begin
                $display("%0t: unexpected beat: kind %0d seq 0x%0h", $time, m_tuser,
                         m_tdata[31:0]);
                mismatches++;
            end else begin
                want = expected_descs.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("seq_number", want.seq, m_tdata[31:0]);
                check_field("byte_offset", want.offset, m_tdata[63:32]);
                check_field("chunk_length", 32'(want.len), 32'(m_tdata[74:64]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("go_back_n_sender test failed");
            $finish;
        end
    end

    task automatic test_idle_events();
        send_event(MODE_TIMEOUT, 1'b0, 32'h0);
        send_event(MODE_RX, 1'b1, 32'h0);
        send_event(MODE_UNUSED, 1'b1, 32'hFFFF_FFFF);
    endtask

    // reset values: empty transfer, FIN limit 10
    task automatic test_empty_transfer();
        send_event(MODE_START, 1'b0, 32'h0);
        send_event(MODE_RX, 1'b0, 32'hFFFF_FFFF);
        send_event(MODE_RX, 1'b1, 32'h0);
        send_event(MODE_TIMEOUT, 1'b1, 32'h0);
    endtask

    task automatic test_fin_limit_zero();
        wait_quiet();
        cfg_write(CFG_FIN_LIMIT, 32'h0);
        send_event(MODE_START, 1'b0, 32'h0);
        send_event(MODE_TIMEOUT, 1'b0, 32'h0);
    endtask

    // window 0 acts as 1; short last chunk
    task automatic test_single_window();
        wait_quiet();
        cfg_write(CFG_TOTAL_BYTES, 3 * CHUNK + 5);
        cfg_write(CFG_WINDOW_SIZE, 32'hABCD_EF80);
        send_event(MODE_START, 1'b0, 32'h0);
        send_event(MODE_RX, 1'b1, 32'd0);
        send_event(MODE_RX, 1'b1, 32'd0);
        send_event(MODE_RX, 1'b1, 32'd7);
        send_event(MODE_RX, 1'b0, 32'd1);
        send_event(MODE_TIMEOUT, 1'b0, 32'h0);
        send_event(MODE_RX, 1'b1, 32'd1);
        send_event(MODE_RX, 1'b1, 32'd2);
        send_event(MODE_RX, 1'b1, 32'd3);
        send_event(MODE_TIMEOUT, 1'b1, 32'h0);
    endtask

    // window above max, full-size transfer, then shrink mid-transfer
    task automatic test_wide_window();
        wait_quiet();
        cfg_write(CFG_TOTAL_BYTES, 32'hFFFF_FFFF);
        cfg_write(CFG_WINDOW_SIZE, 32'd127);
        send_event(MODE_START, 1'b0, 32'h0);
        send_event(MODE_TIMEOUT, 1'b0, 32'h0);
        send_event(MODE_RX, 1'b1, 32'd63);
        send_event(MODE_START, 1'b1, 32'hFFFF_FFFF);
        wait_quiet();
        cfg_write(CFG_TOTAL_BYTES, 5 * CHUNK);
        send_event(MODE_TIMEOUT, 1'b0, 32'h0);
        send_event(MODE_RX, 1'b1, 32'd2);
        send_event(MODE_RX, 1'b1, 32'd63);
        send_event(MODE_TIMEOUT, 1'b0, 32'h0);
    endtask

    task automatic test_receiver_hold();
        wait_quiet();
        cfg_write(CFG_TOTAL_BYTES, 40 * CHUNK);
        cfg_write(CFG_WINDOW_SIZE, 32'd32);
        cfg_write(CFG_FIN_LIMIT, 32'd3);
        rx_hold_len = 400;
        send_event(MODE_START, 1'b0, 32'h0);
        send_event(MODE_TIMEOUT, 1'b0, 32'h0);
        send_event(MODE_TIMEOUT, 1'b1, 32'h0);
        send_event(MODE_RX, 1'b1, 32'd10);
    endtask

    task automatic random_config();
        int r;
        logic [31:0] total;
        logic [6:0]  win;
        if ($urandom_range(0, 9) < 8) begin
            r = $urandom_range(0, 9);
            if (r == 0) total = 0;
            else if (r < 8) total = $urandom_range(1, 40 * CHUNK);
            else if (r == 8) total = $urandom_range(1, 30) * CHUNK;
            else total = $urandom;
            cfg_write(CFG_TOTAL_BYTES, total);
        end
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, 99);
            if (r < 60) win = $urandom_range(1, 8);
            else if (r < 80) win = $urandom_range(9, 32);
            else if (r < 88) win = MAX_WIN;
            else if (r < 94) win = 0;
            else win = $urandom_range(65, 127);
            cfg_write(CFG_WINDOW_SIZE, {25'($urandom_range(0, 3) == 0 ? $urandom : 0), win});
        end
        if ($urandom_range(0, 9) < 6)
            cfg_write(CFG_FIN_LIMIT, $urandom_range(0, 15));
    endtask

    task automatic random_send_event();
        int r;
        logic [31:0] ack;
        r = $urandom_range(0, 99);
        if (r < 55 && next_seq != win_base) begin
            if ($urandom_range(0, 2) == 0) ack = next_seq - 1;
            else ack = win_base + $urandom_range(0, next_seq - win_base - 1);
            send_event(MODE_RX, 1'b1, ack);
        end else if (r < 67) begin
            send_event(MODE_TIMEOUT, 1'($urandom), $urandom);
        end else if (r < 75) begin
            ack = (win_base != 0) ? $urandom_range(0, win_base - 1)
                                  : next_seq + $urandom_range(0, 5);
            send_event(MODE_RX, 1'b1, ack);
        end else if (r < 80) begin
            send_event(MODE_RX, 1'b1, next_seq + $urandom_range(0, 1000));
        end else if (r < 88) begin
            send_event(MODE_RX, 1'b0, $urandom);
        end else if (r < 93) begin
            send_event(MODE_UNUSED, 1'($urandom), $urandom);
        end else if (r < 96) begin
            send_event(MODE_START, 1'($urandom), $urandom);
        end else begin
            send_event(MODE_RX, 1'b1, $urandom);
        end
    endtask

    task automatic random_fin_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) send_event(MODE_TIMEOUT, 1'($urandom), $urandom);
        else if (r < 65) send_event(MODE_RX, 1'b0, $urandom);
        else if (r < 90) send_event(MODE_RX, 1'b1, $urandom);
        else send_event(MODE_UNUSED, 1'($urandom), $urandom);
    endtask

    task automatic test_random_transfers();
        int base_count;
        base_count = productive_events;
        while (productive_events - base_count < RANDOM_EVENTS) begin
            wait_quiet();
            s_idle_en = ($urandom_range(0, 3) != 0);
            m_idle_en = ($urandom_range(0, 3) != 0);
            random_config();
            send_event(MODE_START, 1'($urandom), $urandom);
            for (int n = 0; n < 80 && (tx_phase == PH_SEND || tx_phase == PH_FIN); n++) begin
                if (tx_phase == PH_SEND) begin
                    if ($urandom_range(0, 99) < 3) begin
                        wait_quiet();
                        if ($urandom_range(0, 1) == 0)
                            cfg_write(CFG_TOTAL_BYTES, $urandom_range(0, 40 * CHUNK));
                        else
                            cfg_write(CFG_WINDOW_SIZE, $urandom_range(0, 40));
                    end
                    random_send_event();
                end else begin
                    random_fin_event();
                end
            end
            if ($urandom_range(0, 3) == 0)
                send_event(2'($urandom_range(1, 3)), 1'($urandom), $urandom);
        end
    endtask

    initial begin
        reset_window_model();
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_events();
        test_empty_transfer();
        test_fin_limit_zero();
        test_single_window();
        test_wide_window();
        m_idle_en = 1'b1;
        s_idle_en = 1'b1;
        test_receiver_hold();
        test_random_transfers();

        wait_quiet();
        if (mismatches == 0) begin
            $display("go_back_n_sender test passed");
        end else begin
            $display("go_back_n_sender test failed");
        end
        $finish;
    end

endmodule
